FILE: sv/worker_load_dispatcher_macros.svh
// Assertion helpers for the dispatcher control module.
`ifndef WORKER_LOAD_DISPATCHER_MACROS_SVH
`define WORKER_LOAD_DISPATCHER_MACROS_SVH

// Check on every rising edge outside reset.
`define WLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising edge, reset included.
`define WLD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/wld_pkg.sv
package wld_pkg;

  localparam int MAX_SLOTS           = 16;
  localparam int INITIAL_GROWN_SLOTS = 4;
  localparam int COUNT_BITS          = 16;

  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int ACT_W  = $clog2(MAX_SLOTS + 1);
  localparam int SIZE_W = 16;

  localparam int FIXED_DEFAULT = 10;
  localparam int LIMIT_DEFAULT = 100;
  localparam int GROWN_SLOTS   =
      (INITIAL_GROWN_SLOTS > MAX_SLOTS) ? MAX_SLOTS : INITIAL_GROWN_SLOTS;

  // Configuration register indexes.
  localparam logic CFG_POOL_MODE    = 1'b0;
  localparam logic CFG_SIZE_SETTING = 1'b1;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [ACT_W-1:0]      act_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [SIZE_W-1:0]     size_t;
  typedef logic [3:0]            wid_t;
  typedef logic [3:0]            gid_t;
  typedef logic [MAX_SLOTS-1:0]  slot_vec_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_BAD_SLOT = 2'd2,
    STS_ZERO     = 2'd3
  } status_e;

  // Packed so that granted_id lands in the lowest bits of the output word.
  typedef struct packed {
    logic    slot_removed;
    logic    start_worker;
    status_e status;
    gid_t    granted_id;
  } res_t;

  typedef struct packed {
    logic   re;
    idx_t   raddr;
    logic   we;
    idx_t   waddr;
    count_t wdata;
  } mem_req_t;

endpackage

FILE: sv/wld_load_mem.sv
module wld_load_mem (
  input  logic                clk_i,
  input  wld_pkg::mem_req_t   req_i,
  output wld_pkg::count_t     rdata_o
);

  wld_pkg::count_t mem_q [wld_pkg::MAX_SLOTS];
  wld_pkg::count_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/wld_ctrl.sv
`include "worker_load_dispatcher_macros.svh"

module wld_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_mode_i,
  input  wld_pkg::size_t      cfg_size_i,
  input  logic                s_valid_i,
  input  logic [1:0]          s_action_i,
  input  wld_pkg::wid_t       s_wid_i,
  output logic                s_ready_o,
  output logic                res_valid_o,
  output wld_pkg::res_t       res_o,
  input  logic                out_free_i,
  output wld_pkg::mem_req_t   mem_req_o,
  input  wld_pkg::count_t     mem_rdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SCAN    = 4'b0010,
    ST_RESOLVE = 4'b0100,
    ST_PUSH    = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  wld_pkg::action_e     act_q, act_d;
  wld_pkg::wid_t        wid_q, wid_d;
  wld_pkg::idx_t        idx_q, idx_d;
  logic                 found_q, found_d;
  wld_pkg::idx_t        pick_q, pick_d;
  wld_pkg::count_t      best_q, best_d;
  wld_pkg::slot_vec_t   valid_q, valid_d;
  wld_pkg::slot_vec_t   live_q, live_d;
  wld_pkg::act_t        active_q, active_d;
  logic                 ready_q, ready_d;
  logic                 hmode_q, hmode_d;
  wld_pkg::count_t      hlimit_q, hlimit_d;
  wld_pkg::res_t        res_q, res_d;

  wld_pkg::mem_req_t    mem_req;
  wld_pkg::count_t      cur;
  wld_pkg::size_t       size_eff;
  wld_pkg::act_t        init_n;
  wld_pkg::slot_vec_t   init_mask;
  wld_pkg::count_t      init_limit;
  wld_pkg::idx_t        free_idx;
  logic                 free_any;
  logic                 wid_ok;
  wld_pkg::idx_t        wid_idx;
  wld_pkg::action_e     in_act;

  // Pool setup values, taken from the registers on the first item.
  always_comb begin
    if (cfg_size_i == '0) begin
      size_eff = cfg_mode_i ? wld_pkg::size_t'(wld_pkg::LIMIT_DEFAULT)
                            : wld_pkg::size_t'(wld_pkg::FIXED_DEFAULT);
    end else begin
      size_eff = cfg_size_i;
    end
    if (cfg_mode_i) begin
      init_n = wld_pkg::act_t'(wld_pkg::GROWN_SLOTS);
    end else if (int'(size_eff) > wld_pkg::MAX_SLOTS) begin
      init_n = wld_pkg::act_t'(wld_pkg::MAX_SLOTS);
    end else begin
      init_n = wld_pkg::act_t'(size_eff);
    end
    if (32'(size_eff) > 32'(wld_pkg::COUNT_MAX)) begin
      init_limit = wld_pkg::COUNT_MAX;
    end else begin
      init_limit = wld_pkg::count_t'(size_eff);
    end
    for (int i = 0; i < wld_pkg::MAX_SLOTS; i++) begin
      init_mask[i] = (i < int'(init_n));
    end
  end

  // Lowest free slot for growing the pool.
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = wld_pkg::MAX_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = wld_pkg::idx_t'(i);
        free_any = 1'b1;
      end
    end
  end

  assign wid_ok  = int'(wid_q) < wld_pkg::MAX_SLOTS;
  assign wid_idx = wld_pkg::idx_t'(wid_q);
  assign in_act  = wld_pkg::action_e'(s_action_i);
  // An entry not written since the last clear reads as zero.
  assign cur     = live_q[idx_q] ? mem_rdata_i : '0;

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    wid_d    = wid_q;
    idx_d    = idx_q;
    found_d  = found_q;
    pick_d   = pick_q;
    best_d   = best_q;
    valid_d  = valid_q;
    live_d   = live_q;
    active_d = active_q;
    ready_d  = ready_q;
    hmode_d  = hmode_q;
    hlimit_d = hlimit_q;
    res_d    = res_q;
    mem_req  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          act_d   = in_act;
          wid_d   = s_wid_i;
          found_d = 1'b0;
          pick_d  = '0;
          best_d  = '0;
          res_d   = '0;
          idx_d   = (in_act == wld_pkg::ACT_ACQUIRE) ? '0 : wld_pkg::idx_t'(s_wid_i);
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_d;
          if (!ready_q) begin
            ready_d  = 1'b1;
            hmode_d  = cfg_mode_i;
            hlimit_d = cfg_mode_i ? init_limit : '0;
            valid_d  = init_mask;
            active_d = init_n;
            live_d   = '0;
          end
          unique case (in_act)
            wld_pkg::ACT_ACQUIRE, wld_pkg::ACT_RELEASE: state_d = ST_SCAN;
            wld_pkg::ACT_CLEAR: begin
              live_d  = '0;
              state_d = ST_PUSH;
            end
            default: state_d = ST_PUSH;
          endcase
        end
      end

      ST_SCAN: begin
        if (act_q == wld_pkg::ACT_RELEASE) begin
          best_d  = cur;
          state_d = ST_RESOLVE;
        end else begin
          if (valid_q[idx_q]) begin
            if (!hmode_q) begin
              if (!found_q || cur < best_q) begin
                found_d = 1'b1;
                pick_d  = idx_q;
                best_d  = cur;
              end
            end else if (!found_q && cur < hlimit_q) begin
              found_d = 1'b1;
              pick_d  = idx_q;
              best_d  = cur;
            end
          end
          if (int'(idx_q) == wld_pkg::MAX_SLOTS - 1) begin
            state_d = ST_RESOLVE;
          end else begin
            idx_d         = idx_q + 1'b1;
            mem_req.re    = 1'b1;
            mem_req.raddr = idx_d;
          end
        end
      end

      ST_RESOLVE: begin
        state_d = ST_PUSH;
        if (act_q == wld_pkg::ACT_ACQUIRE) begin
          if (found_q) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pick_q;
            mem_req.wdata = (best_q == wld_pkg::COUNT_MAX) ? best_q : best_q + 1'b1;
            live_d[pick_q]     = 1'b1;
            res_d.granted_id   = wld_pkg::gid_t'(pick_q);
            res_d.start_worker = hmode_q && (best_q == '0);
          end else if (hmode_q) begin
            if (free_any) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = free_idx;
              mem_req.wdata = wld_pkg::count_t'(1);
              live_d[free_idx]   = 1'b1;
              valid_d[free_idx]  = 1'b1;
              active_d           = active_q + 1'b1;
              res_d.granted_id   = wld_pkg::gid_t'(free_idx);
              res_d.start_worker = 1'b1;
            end else begin
              res_d.status = wld_pkg::STS_FULL;
            end
          end
        end else begin
          if (!wid_ok || !valid_q[wid_idx]) begin
            res_d.status = wld_pkg::STS_BAD_SLOT;
          end else if (best_q == '0) begin
            res_d.status = wld_pkg::STS_ZERO;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = wid_idx;
            mem_req.wdata = best_q - 1'b1;
            live_d[wid_idx] = 1'b1;
            if (hmode_q && best_q == wld_pkg::count_t'(1) && active_q > wld_pkg::act_t'(1)) begin
              valid_d[wid_idx]   = 1'b0;
              active_d           = active_q - 1'b1;
              res_d.slot_removed = 1'b1;
            end
          end
        end
      end

      ST_PUSH: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      live_q   <= '0;
      active_q <= '0;
      ready_q  <= 1'b0;
      hmode_q  <= 1'b0;
      hlimit_q <= '0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      live_q   <= live_d;
      active_q <= active_d;
      ready_q  <= ready_d;
      hmode_q  <= hmode_d;
      hlimit_q <= hlimit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    wid_q   <= wid_d;
    idx_q   <= idx_d;
    found_q <= found_d;
    pick_q  <= pick_d;
    best_q  <= best_d;
    res_q   <= res_d;
  end

  assign s_ready_o   = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_PUSH);
  assign res_o       = res_q;
  assign mem_req_o   = mem_req;

  `WLD_ASSERT(a_active_matches_valid, $countones(valid_q) == int'(active_q), "active count drifted from valid bits")
  `WLD_ASSERT(a_pool_never_empty, ready_q |-> active_q != '0, "pool lost its last slot")
  `WLD_ASSERT(a_start_is_ok, (res_valid_o && res_q.start_worker) |-> (res_q.status == wld_pkg::STS_OK && !res_q.slot_removed), "start flagged on a failed or release result")
  `WLD_ASSERT(a_written_is_live, mem_req.we |=> live_q[$past(mem_req.waddr)], "written entry not marked live")

endmodule

FILE: sv/worker_load_dispatcher.sv
// Acquire sweeps the load memory over all slots, one read a cycle, then writes back the pick;
// release reads and writes back the named slot; clear and the unused action go straight to
// the result word. A new item is taken only once the last word has gone to the output register.
// A finished word waits in the output register while the next item is taken and worked on.
// Reset (rst_ni low, asynchronous) empties the pool and zeroes all loads at once through
// per-slot live bits; the first item after reset builds the pool from the registers.
module worker_load_dispatcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // request stream
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [3:0] worker_id, [7:4] zero
  input  logic [1:0]  s_tuser_i,   // [1:0] action
  // result stream
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [7:0]  m_tdata_o    // [3:0] granted_id, [5:4] status, [6] start_worker,
                                   // [7] slot_removed
);

  logic                mode_q;
  wld_pkg::size_t      size_q;
  logic                out_valid_q;
  wld_pkg::res_t       out_q;
  logic                out_free;
  logic                res_valid;
  wld_pkg::res_t       res;
  wld_pkg::mem_req_t   mem_req;
  wld_pkg::count_t     mem_rdata;

  // Register writes are only to be made while the block is idle, which the block does not
  // enforce; the pool latches them on its first item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      size_q <= wld_pkg::size_t'(wld_pkg::FIXED_DEFAULT);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wld_pkg::CFG_POOL_MODE:    mode_q <= cfg_wdata_i[0];
        wld_pkg::CFG_SIZE_SETTING: size_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  wld_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_mode_i  (mode_q),
    .cfg_size_i  (size_q),
    .s_valid_i   (s_tvalid_i),
    .s_action_i  (s_tuser_i),
    .s_wid_i     (s_tdata_i[3:0]),
    .s_ready_o   (s_tready_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .out_free_i  (out_free),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  wld_load_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register: load a new word when empty or when the current one leaves.
  assign out_free = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_q;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

// Scoreboard: tracks the slot pool and queues the expected result words.
class dispatch_scoreboard;
  wld_pkg::count_t load [wld_pkg::MAX_SLOTS];
  bit              live [wld_pkg::MAX_SLOTS];
  int              live_count;
  bit              built;
  bit              reg_mode;
  wld_pkg::size_t  reg_size;
  bit              held_mode;
  wld_pkg::count_t held_limit;
  wld_pkg::res_t   expected_q[$];
  int     errors, words_checked, requests, grants, full_hits, freed, bad_hits, zero_hits;

  function new();
    foreach (load[i]) begin
      load[i] = '0;
      live[i] = 1'b0;
    end
    live_count = 0;
    built      = 1'b0;
    reg_mode   = 1'b0;
    reg_size   = 16'd10;
    held_mode  = 1'b0;
    held_limit = '0;
    errors = 0; words_checked = 0; requests = 0; grants = 0;
    full_hits = 0; freed = 0; bad_hits = 0; zero_hits = 0;
  endfunction

  function void note_config(bit idx, wld_pkg::size_t val);
    if (idx == wld_pkg::CFG_POOL_MODE) reg_mode = val[0];
    else reg_size = val;
  endfunction

  function void add_slot(int idx, wld_pkg::count_t first_load);
    live[idx] = 1'b1;
    load[idx] = first_load;
    live_count++;
  endfunction

  // Latch mode and size on the first request after reset.
  function void build_pool();
    int          n;
    int unsigned want;
    held_mode = reg_mode;
    if (!held_mode) begin
      want       = (reg_size == 0) ? wld_pkg::FIXED_DEFAULT : reg_size;
      n          = (want > wld_pkg::MAX_SLOTS) ? wld_pkg::MAX_SLOTS : want;
      held_limit = '0;
    end else begin
      want       = (reg_size == 0) ? wld_pkg::LIMIT_DEFAULT : reg_size;
      held_limit = (want > wld_pkg::COUNT_MAX) ? wld_pkg::COUNT_MAX
                                               : wld_pkg::count_t'(want);
      n          = wld_pkg::GROWN_SLOTS;
    end
    for (int i = 0; i < n; i++) add_slot(i, '0);
    built = 1'b1;
  endfunction

  function void note_request(wld_pkg::action_e act, wld_pkg::wid_t wid);
    wld_pkg::res_t r;
    int   pick;
    bit   found;
    r     = '0;
    pick  = 0;
    found = 1'b0;
    requests++;
    if (!built) build_pool();
    case (act)
      wld_pkg::ACT_ACQUIRE: begin
        if (!held_mode) begin
          // least loaded, ties to the lowest index
          for (int i = 0; i < wld_pkg::MAX_SLOTS; i++)
            if (live[i] && (!found || load[i] < load[pick])) begin
              pick  = i;
              found = 1'b1;
            end
          if (found) begin
            if (load[pick] != wld_pkg::COUNT_MAX) load[pick]++;
            r.granted_id = wld_pkg::gid_t'(pick);
          end
        end else begin
          // first fit below the limit, else grow into the lowest free slot
          for (int i = 0; i < wld_pkg::MAX_SLOTS && !found; i++)
            if (live[i] && load[i] < held_limit) begin
              pick  = i;
              found = 1'b1;
            end
          if (found) begin
            r.start_worker = (load[pick] == 0);
            load[pick]++;
            r.granted_id = wld_pkg::gid_t'(pick);
          end else begin
            for (int i = 0; i < wld_pkg::MAX_SLOTS && !found; i++)
              if (!live[i]) begin
                pick  = i;
                found = 1'b1;
              end
            if (found) begin
              add_slot(pick, wld_pkg::count_t'(1));
              r.start_worker = 1'b1;
              r.granted_id   = wld_pkg::gid_t'(pick);
            end else begin
              r.status = wld_pkg::STS_FULL;
            end
          end
        end
        if (r.status == wld_pkg::STS_OK) grants++;
        else full_hits++;
      end
      wld_pkg::ACT_RELEASE: begin
        if (int'(wid) >= wld_pkg::MAX_SLOTS || !live[wid]) begin
          r.status = wld_pkg::STS_BAD_SLOT;
          bad_hits++;
        end else if (load[wid] == 0) begin
          r.status = wld_pkg::STS_ZERO;
          zero_hits++;
        end else begin
          load[wid]--;
          if (held_mode && load[wid] == 0 && live_count > 1) begin
            live[wid] = 1'b0;
            live_count--;
            r.slot_removed = 1'b1;
            freed++;
          end
        end
      end
      wld_pkg::ACT_CLEAR: foreach (load[i]) load[i] = '0;
      default: ;
    endcase
    expected_q.push_back(r);
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task check_result(logic [7:0] word);
    wld_pkg::res_t got, want;
    got = word;
    words_checked++;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result word %h with no request outstanding", word));
      return;
    end
    want = expected_q.pop_front();
    if (got.granted_id !== want.granted_id)
      report_mismatch($sformatf("word %0d granted_id %0d, expected %0d",
                                words_checked, got.granted_id, want.granted_id));
    if (got.status !== want.status)
      report_mismatch($sformatf("word %0d status %0d, expected %0d",
                                words_checked, got.status, want.status));
    if (got.start_worker !== want.start_worker)
      report_mismatch($sformatf("word %0d start_worker %0d, expected %0d",
                                words_checked, got.start_worker, want.start_worker));
    if (got.slot_removed !== want.slot_removed)
      report_mismatch($sformatf("word %0d slot_removed %0d, expected %0d",
                                words_checked, got.slot_removed, want.slot_removed));
  endtask
endclass

module testbench;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_tvalid_i  = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i   = '0;  // [3:0] worker_id, [7:4] zero
  logic [1:0]  s_tuser_i   = '0;  // [1:0] action
  logic        m_tvalid_o;
  logic        m_tready_i  = 1'b0;
  logic [7:0]  m_tdata_o;         // [3:0] granted_id, [5:4] status, [6] start_worker,
                                  // [7] slot_removed

  dispatch_scoreboard sb;

  // Idle percentages for sender and receiver, set per phase by the main sequence.
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  // Long receiver hold-off, counted down by the receiver process.
  int   hold_cycles   = 0;
  bit             init_mode;
  wld_pkg::size_t init_size;

  worker_load_dispatcher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o)
  );

  always #10 clk_i = ~clk_i;

  // Write both registers on back-to-back edges; the enable drops once after the pair.
  task write_regs(bit mode, wld_pkg::size_t size);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= wld_pkg::CFG_POOL_MODE;
    cfg_wdata_i <= {15'b0, mode};
    @(posedge clk_i);
    sb.note_config(wld_pkg::CFG_POOL_MODE, {15'b0, mode});
    cfg_idx_i   <= wld_pkg::CFG_SIZE_SETTING;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    sb.note_config(wld_pkg::CFG_SIZE_SETTING, size);
    cfg_we_i    <= 1'b0;
  endtask

  // Offer one request word and hold it until the block takes it. Valid stays high
  // afterwards so that back-to-back words need no extra edge.
  task send_word(wld_pkg::action_e act, wld_pkg::wid_t wid);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(22, 1)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {4'b0, wid};
    s_tuser_i  <= act;
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_request(act, wid);
  endtask

  // Wait until every expected word has come back.
  task drain();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Corner requests: setup on a release, unused action, invalid and zero-count
  // releases, clear, and runs of acquires that spread load or grow the pool.
  task run_directed();
    send_word(wld_pkg::ACT_RELEASE, 4'd0);
    send_word(wld_pkg::ACT_NONE, 4'hF);
    for (int i = 0; i < 6; i++) send_word(wld_pkg::ACT_ACQUIRE, wld_pkg::wid_t'(i * 3));
    send_word(wld_pkg::ACT_RELEASE, 4'hF);
    send_word(wld_pkg::ACT_RELEASE, 4'd0);
    send_word(wld_pkg::ACT_RELEASE, 4'd0);
    send_word(wld_pkg::ACT_CLEAR, 4'hA);
    send_word(wld_pkg::ACT_RELEASE, 4'd1);
    for (int i = 0; i < 8; i++) send_word(wld_pkg::ACT_ACQUIRE, wld_pkg::wid_t'(15 - i));
    send_word(wld_pkg::ACT_RELEASE, 4'd2);
    send_word(wld_pkg::ACT_RELEASE, 4'd2);
    send_word(wld_pkg::ACT_NONE, 4'd0);
    s_tvalid_i <= 1'b0;
  endtask

  // Random traffic in stretches that lean toward acquire (pool grows, fills up)
  // or release (slots drain and get freed). Most releases name a live slot.
  task send_random(int count);
    int               acq_pct;
    int               r;
    wld_pkg::action_e act;
    wld_pkg::wid_t    wid;
    int               picks[$];
    acq_pct = 50;
    for (int k = 0; k < count; k++) begin
      if (k % 50 == 0) begin
        case ($urandom_range(2))
          0:       acq_pct = 70;
          1:       acq_pct = 30;
          default: acq_pct = 50;
        endcase
      end
      r   = $urandom_range(99);
      wid = wld_pkg::wid_t'($urandom_range(15));
      if (r < acq_pct) begin
        act = wld_pkg::ACT_ACQUIRE;
      end else if (r < 92) begin
        act = wld_pkg::ACT_RELEASE;
        if ($urandom_range(9) < 8) begin
          picks.delete();
          foreach (sb.live[i]) if (sb.live[i]) picks.push_back(i);
          if (picks.size() != 0)
            wid = wld_pkg::wid_t'(picks[$urandom_range(picks.size() - 1)]);
        end
      end else if (r < 96) begin
        act = wld_pkg::ACT_CLEAR;
      end else begin
        act = wld_pkg::ACT_NONE;
      end
      send_word(act, wid);
    end
    s_tvalid_i <= 1'b0;
  endtask

  // Receiver: check each accepted word, then decide tready for the next edge.
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_tvalid_o && m_tready_i) sb.check_result(m_tdata_o);
      if (hold_cycles > 0) begin
        m_tready_i <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    sb = new();

    // The pool is latched once per reset, so pick this run's mode and size here.
    init_mode = $urandom_range(1);
    if (init_mode) begin
      case ($urandom_range(9))
        0:       init_size = 16'd0;
        1:       init_size = 16'hFFFF;
        2, 3:    init_size = wld_pkg::size_t'($urandom_range(8, 4));
        default: init_size = wld_pkg::size_t'($urandom_range(3, 1));
      endcase
    end else begin
      case ($urandom_range(6))
        0:       init_size = 16'd0;
        1:       init_size = 16'd1;
        2:       init_size = 16'd16;
        3:       init_size = 16'd17;
        4:       init_size = 16'hFFFF;
        default: init_size = wld_pkg::size_t'($urandom_range(15, 2));
      endcase
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_regs(init_mode, init_size);
    run_directed();

    // Phases: no idling (with a long receiver hold-off), sender idle,
    // receiver stalling, both idling a little.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 45; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 45; end
        default: begin send_idle_pct = 9;  stall_pct = 9;  end
      endcase
      drain();
      // Register writes after setup must leave the latched pool alone.
      case (ph)
        0:       write_regs(~init_mode, 16'h0000);
        1:       write_regs(init_mode, 16'hFFFF);
        2:       write_regs(~init_mode, 16'h0001);
        default: write_regs(init_mode, wld_pkg::size_t'($urandom_range(16'hFFFF)));
      endcase
      if (ph == 0) hold_cycles = 400;
      send_random(500);
    end

    drain();
    repeat (40) @(posedge clk_i);

    $display("Sent %0d requests, pool mode %0d, size setting %0d: %0d grants, %0d pool full,",
             sb.requests, init_mode, init_size, sb.grants, sb.full_hits);
    $display("%0d slots freed, %0d bad-slot and %0d zero-count releases, %0d words checked.",
             sb.freed, sb.bad_hits, sb.zero_hits, sb.words_checked);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/wld_pkg.sv
sv/wld_load_mem.sv
sv/wld_ctrl.sv
sv/worker_load_dispatcher.sv
tb/testbench.sv
